### hw/rtl/dssf_pkg.sv
// Shared types, constants and digit helpers for the decimal seven-segment framer.
package dssf_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int FRAME_LEN   = DIGIT_COUNT + 2;
   localparam int IDX_W       = $clog2(FRAME_LEN);
   localparam int VALUE_W     = 16;
   localparam int REM_W       = 14;
   localparam int BRIGHT_W    = 4;
   localparam int MOD_BASE    = 10000;
   localparam int MOD_QMAX    = 65535 / MOD_BASE;
   localparam int SEP_POS     = 2;

   localparam logic [IDX_W-1:0]    ADDR_IDX   = IDX_W'(1);
   localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(FRAME_LEN - 1);
   localparam logic                CMD_SHOW   = 1'b0;
   localparam logic                CMD_BRIGHT = 1'b1;
   localparam logic [7:0]          DATA_CMD   = 8'h40;
   localparam logic [7:0]          ADDR_CMD   = 8'hC0;
   localparam logic [7:0]          CTRL_CMD   = 8'h87;
   localparam logic [7:0]          SEP_MASK   = 8'h80;
   localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = BRIGHT_W'(8);
   localparam logic [BRIGHT_W-1:0] BRIGHT_RST = BRIGHT_W'(8);

   typedef struct packed {
      logic               cmd;
      logic [VALUE_W-1:0] value;
      logic               separator;
   } item_type;

   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] p;
      case (digit)
         4'd0:    p = 8'h3F;
         4'd1:    p = 8'h06;
         4'd2:    p = 8'h5B;
         4'd3:    p = 8'h4F;
         4'd4:    p = 8'h66;
         4'd5:    p = 8'h6D;
         4'd6:    p = 8'h7D;
         4'd7:    p = 8'h07;
         4'd8:    p = 8'h7F;
         4'd9:    p = 8'h6F;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

   function automatic logic [REM_W-1:0] pow10(input logic [IDX_W-1:0] pos);
      logic [REM_W-1:0] p;
      case (pos)
         IDX_W'(0): p = REM_W'(1);
         IDX_W'(1): p = REM_W'(10);
         IDX_W'(2): p = REM_W'(100);
         IDX_W'(3): p = REM_W'(1000);
         default:   p = REM_W'(1);
      endcase
      return p;
   endfunction

   // digit = number of multiples j*pw (j = 1..9) not above rem
   function automatic logic [3:0] digit_of(input logic [REM_W-1:0] rem,
                                           input logic [REM_W-1:0] pw);
      logic [3:0]       d;
      logic [REM_W+3:0] lim;
      d = 4'd0;
      for (int j = 1; j <= 9; j++) begin
         lim = (REM_W+4)'(j) * {4'd0, pw};
         if ({4'd0, rem} >= lim) d = 4'(j);
      end
      return d;
   endfunction

   // value modulo MOD_BASE by parallel compares against the few multiples
   function automatic logic [REM_W-1:0] low_digits(input logic [VALUE_W-1:0] v);
      logic [VALUE_W:0] sub;
      logic [VALUE_W:0] lim;
      sub = '0;
      for (int j = 1; j <= MOD_QMAX; j++) begin
         lim = (VALUE_W+1)'(j * MOD_BASE);
         if ({1'b0, v} >= lim) sub = lim;
      end
      return REM_W'({1'b0, v} - sub);
   endfunction

endpackage

### hw/rtl/dssf_in_reg.sv
// Input register: holds one accepted request until the framer takes it.
module dssf_in_reg
   import dssf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_separator,
   output logic               item_valid,
   output item_type           item,
   input  logic               item_take
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     load;

   assign req_stall  = valid_ff && !item_take;
   assign load       = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.cmd       <= req_cmd;
         item_ff.value     <= req_value;
         item_ff.separator <= req_separator;
      end
   end

endmodule

### hw/rtl/dssf_framer.sv
// Byte sequencer: digit extraction, segment mapping and the result register.
module dssf_framer
   import dssf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  item_type            item,
   output logic                item_take,
   input  logic [BRIGHT_W-1:0] brightness,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_tx_byte,
   output logic                rsp_start_before,
   output logic                rsp_stop_after,
   output logic                rsp_last
);

   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic             sep_ff, sep_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             start_ff, start_in;
   logic             stop_ff, stop_in;
   logic             last_ff, last_in;

   logic                advance;
   logic [IDX_W-1:0]    pos;
   logic [REM_W-1:0]    pw;
   logic [3:0]          digit;
   logic [7:0]          pattern;
   logic [BRIGHT_W-1:0] bright_sat;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign item_take = advance && !busy_ff && item_valid;

   assign pos        = LAST_IDX - idx_ff;
   assign pw         = pow10(pos);
   assign digit      = digit_of(rem_ff, pw);
   assign bright_sat = (brightness > BRIGHT_MAX) ? BRIGHT_MAX : brightness;

   always_comb begin
      pattern = seg_pattern(digit);
      if (sep_ff && (pos == IDX_W'(SEP_POS))) begin
         pattern = pattern | SEP_MASK;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      sep_in       = sep_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      byte_in      = byte_ff;
      start_in     = start_ff;
      stop_in      = stop_ff;
      last_in      = last_ff;
      if (advance) begin
         if (busy_ff) begin
            out_valid_in = 1'b1;
            idx_in       = idx_ff + IDX_W'(1);
            if (idx_ff == ADDR_IDX) begin
               byte_in  = ADDR_CMD;
               start_in = 1'b1;
               stop_in  = 1'b0;
               last_in  = 1'b0;
            end else begin
               byte_in  = pattern;
               start_in = 1'b0;
               stop_in  = (idx_ff == LAST_IDX);
               last_in  = (idx_ff == LAST_IDX);
               rem_in   = rem_ff - REM_W'({{REM_W{1'b0}}, digit} * {4'd0, pw});
               if (idx_ff == LAST_IDX) begin
                  busy_in = 1'b0;
               end
            end
         end else if (item_valid) begin
            out_valid_in = 1'b1;
            start_in     = 1'b1;
            stop_in      = 1'b1;
            if (item.cmd == CMD_BRIGHT) begin
               byte_in = CTRL_CMD + {{(8-BRIGHT_W){1'b0}}, bright_sat};
               last_in = 1'b1;
            end else begin
               byte_in = DATA_CMD;
               last_in = 1'b0;
               busy_in = 1'b1;
               idx_in  = ADDR_IDX;
               rem_in  = low_digits(item.value);
               sep_in  = item.separator;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      sep_ff   <= sep_in;
      byte_ff  <= byte_in;
      start_ff <= start_in;
      stop_ff  <= stop_in;
      last_ff  <= last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_tx_byte      = byte_ff;
   assign rsp_start_before = start_ff;
   assign rsp_stop_after   = stop_ff;
   assign rsp_last         = last_ff;

endmodule

### hw/rtl/decimal_seven_segment_framer.sv
// Top level: brightness register, input register and byte framer.
// The first byte of a request passes through the input register and then the
// result register before it is offered on rsp_valid.
// Throughput: one byte per cycle from the result register while rsp_stall is
// low; a show request yields six bytes, a brightness request one.
// Reset (synchronous): clears all valids and the sequencer, brightness = 8.
module decimal_seven_segment_framer
   import dssf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic                req_separator,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_tx_byte,
   output logic                rsp_start_before,
   output logic                rsp_stop_after,
   output logic                rsp_last,
   input  logic                csr_wr_en,
   input  logic [BRIGHT_W-1:0] csr_wr_data
);

   logic [BRIGHT_W-1:0] brightness_ff, brightness_in;
   logic                item_valid;
   item_type            item;
   logic                item_take;

   assign brightness_in = csr_wr_en ? csr_wr_data : brightness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHT_RST;
      end else begin
         brightness_ff <= brightness_in;
      end
   end

   dssf_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .req_separator (req_separator),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take)
   );

   dssf_framer u_framer (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take),
      .brightness       (brightness_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_start_before (rsp_start_before),
      .rsp_stop_after   (rsp_stop_after),
      .rsp_last         (rsp_last)
   );

endmodule
